// ===== sv/ppm_frame_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// ppm frame decoder assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_CORE_ASSERT_SVH
`define PPM_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PPMFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ppm frame decoder check failed");
`define PPMFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppm frame decoder check failed");
`else
`define PPMFD_ASSERT(lbl, prop)
`define PPMFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmfd_pkg
// shared constants and types of the ppm frame decoder
// ----------------------------------------------------------------------------
package ppmfd_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int POS_W        = $clog2(NUM_CHANNELS + 1);
	localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TIME_W       = 32;
	localparam int WIDTH_W      = 16;
	localparam int CHIDX_W      = 4;
	localparam int CFG_IDX_W    = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX = 4'd3;

	localparam logic [WIDTH_W-1:0] SYNC_MIN_RST = 16'd5000;
	localparam logic [WIDTH_W-1:0] SYNC_MAX_RST = 16'd15000;
	localparam logic [WIDTH_W-1:0] DATA_MIN_RST = 16'd800;
	localparam logic [WIDTH_W-1:0] DATA_MAX_RST = 16'd2200;

	typedef logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] width_arr_t;

	typedef struct packed {
		logic       valid;
		width_arr_t widths;
	} emit_t;

endpackage

// ===== sv/ppmfd_frame.sv =====
// ----------------------------------------------------------------------------
// ppmfd_frame
// input register, interval measurement, sync/channel tracking and width store
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_core_assert.svh"

module ppmfd_frame (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ppmfd_pkg::TIME_W-1:0]         edge_time,
	input  logic                                 signal_ok,
	input  logic                                 cfg_valid,
	input  logic [ppmfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppmfd_pkg::WIDTH_W-1:0]        cfg_data,
	output ppmfd_pkg::emit_t                     emit,
	input  logic                                 load_ok
);

	logic                              valid_s1;
	logic [ppmfd_pkg::TIME_W-1:0]      edge_time_s1;
	logic                              signal_ok_s1;

	logic [ppmfd_pkg::WIDTH_W-1:0]     sync_min_q;
	logic [ppmfd_pkg::WIDTH_W-1:0]     sync_max_q;
	logic [ppmfd_pkg::WIDTH_W-1:0]     data_min_q;
	logic [ppmfd_pkg::WIDTH_W-1:0]     data_max_q;

	logic [ppmfd_pkg::TIME_W-1:0]      prev_edge_q;
	logic [ppmfd_pkg::POS_W-1:0]       pos_q;
	logic                              complete_q;
	ppmfd_pkg::width_arr_t             widths_q;

	logic [ppmfd_pkg::TIME_W-1:0]      gap;
	logic                              waiting;
	logic                              sync_hit;
	logic                              data_hit;
	logic                              do_emit;
	logic                              advance;

	assign gap      = edge_time_s1 - prev_edge_q;
	assign waiting  = (pos_q >= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS));
	assign sync_hit = (gap > {16'd0, sync_min_q}) && (gap < {16'd0, sync_max_q});
	assign data_hit = (gap > {16'd0, data_min_q}) && (gap < {16'd0, data_max_q});
	assign do_emit  = valid_s1 && waiting && sync_hit && complete_q && signal_ok_s1;
	// an emitting item holds until the output buffer can take the frame
	assign advance  = valid_s1 && (!do_emit || load_ok);
	assign in_ready = !valid_s1 || advance;

	assign emit.valid  = do_emit;
	assign emit.widths = widths_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			edge_time_s1 <= edge_time;
			signal_ok_s1 <= signal_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q <= ppmfd_pkg::SYNC_MIN_RST;
			sync_max_q <= ppmfd_pkg::SYNC_MAX_RST;
			data_min_q <= ppmfd_pkg::DATA_MIN_RST;
			data_max_q <= ppmfd_pkg::DATA_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppmfd_pkg::REG_SYNC_MIN: sync_min_q <= cfg_data;
				ppmfd_pkg::REG_SYNC_MAX: sync_max_q <= cfg_data;
				ppmfd_pkg::REG_DATA_MIN: data_min_q <= cfg_data;
				ppmfd_pkg::REG_DATA_MAX: data_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_edge_q <= '0;
			pos_q       <= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS);
			complete_q  <= 1'b0;
		end else if (advance) begin
			prev_edge_q <= edge_time_s1;
			if (waiting) begin
				if (sync_hit) begin
					pos_q <= '0;
					// a sync with bad signal keeps the completed flag
					if (do_emit) begin
						complete_q <= 1'b0;
					end
				end else begin
					complete_q <= 1'b0;
				end
			end else if (data_hit) begin
				pos_q <= ppmfd_pkg::POS_W'(pos_q + 1'b1);
				if (pos_q == ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS - 1)) begin
					complete_q <= 1'b1;
				end
			end else begin
				pos_q      <= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS);
				complete_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !waiting && data_hit) begin
			widths_q[pos_q[ppmfd_pkg::IDX_W-1:0]] <= gap[ppmfd_pkg::WIDTH_W-1:0];
		end
	end

	`PPMFD_ASSERT(a_pos_range, pos_q <= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS))
	`PPMFD_ASSERT(a_stall_only_on_emit, (valid_s1 && !in_ready) |-> (do_emit && !load_ok))
	`PPMFD_ASSERT_NEXT(a_emit_clears, advance && do_emit, !complete_q && pos_q == '0)

endmodule

// ===== sv/ppmfd_drain.sv =====
// ----------------------------------------------------------------------------
// ppmfd_drain
// frame output buffer, shifts one channel width out per beat
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_core_assert.svh"

module ppmfd_drain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppmfd_pkg::emit_t                  emit,
	output logic                              load_ok,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ppmfd_pkg::CHIDX_W-1:0]     channel_index,
	output logic [ppmfd_pkg::WIDTH_W-1:0]     pulse_width,
	output logic                              last_in_frame
);

	ppmfd_pkg::width_arr_t             buf_q;
	logic [ppmfd_pkg::POS_W-1:0]       cnt_q;
	logic [ppmfd_pkg::CHIDX_W-1:0]     idx_q;
	logic                              take;
	logic                              load;

	assign out_valid     = (cnt_q != '0);
	assign take          = out_valid && out_ready;
	assign load_ok       = !out_valid || (take && cnt_q == ppmfd_pkg::POS_W'(1));
	assign load          = emit.valid && load_ok;
	assign channel_index = idx_q;
	assign pulse_width   = buf_q[0];
	assign last_in_frame = (cnt_q == ppmfd_pkg::POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS);
			idx_q <= '0;
		end else if (take) begin
			cnt_q <= ppmfd_pkg::POS_W'(cnt_q - 1'b1);
			idx_q <= ppmfd_pkg::CHIDX_W'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= emit.widths;
		end else if (take) begin
			for (int i = 0; i < ppmfd_pkg::NUM_CHANNELS - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	`PPMFD_ASSERT(a_cnt_range, cnt_q <= ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS))
	`PPMFD_ASSERT(a_last_index,
		last_in_frame |-> idx_q == ppmfd_pkg::CHIDX_W'(ppmfd_pkg::NUM_CHANNELS - 1))
	`PPMFD_ASSERT_NEXT(a_load_fills, load,
		cnt_q == ppmfd_pkg::POS_W'(ppmfd_pkg::NUM_CHANNELS) && idx_q == '0)

endmodule

// ===== sv/ppm_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder_core
// decodes ppm radio control frames from pulse edge timestamps
// ----------------------------------------------------------------------------
// in channel: one beat per pulse edge (edge_time, signal_ok), valid/ready.
// out channel: one beat per channel width (channel_index, pulse_width,
//   last_in_frame), valid/ready; a frame of NUM_CHANNELS beats follows a
//   qualifying sync gap, last_in_frame marks its final beat.
// cfg channel: cfg_index/cfg_data write the four 16-bit limits; cfg_ready
//   is always high. Write only while the block is idle.
// path: an edge beat is registered in the input register and evaluated
//   there; a frame it completes is loaded into the output shift buffer.
// throughput: one edge beat per cycle while no completing edge waits. A frame
//   drains one beat per cycle from a shift buffer while out_ready is high;
//   an edge that completes a new frame waits in the input register until
//   the previous frame's last beat is taken.
// reset: limits return to 5000/15000/800/2200, the previous edge to zero,
//   and the decoder waits for sync with no frame pending.
// receiver stall: the current beat holds, other edges keep being accepted
//   until one of them would start another frame.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ppmfd_pkg::TIME_W-1:0]      edge_time,
	input  logic                              signal_ok,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppmfd_pkg::WIDTH_W-1:0]     cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ppmfd_pkg::CHIDX_W-1:0]     channel_index,
	output logic [ppmfd_pkg::WIDTH_W-1:0]     pulse_width,
	output logic                              last_in_frame
);

	ppmfd_pkg::emit_t emit;
	logic             load_ok;

	assign cfg_ready = 1'b1;

	ppmfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.edge_time (edge_time),
		.signal_ok (signal_ok),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.emit      (emit),
		.load_ok   (load_ok)
	);

	ppmfd_drain u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.load_ok       (load_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.pulse_width   (pulse_width),
		.last_in_frame (last_in_frame)
	);

endmodule
